[hdl/sci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg
// Types, round functions and message schedule helpers for the SHA crypto
// instruction unit.
// ----------------------------------------------------------------------------
package sci_pkg;

   localparam int unsigned NUM_ROUNDS = 4;

   typedef enum logic [3:0] {
      OP_SHA1C     = 4'd0,
      OP_SHA1P     = 4'd1,
      OP_SHA1M     = 4'd2,
      OP_SHA1H     = 4'd3,
      OP_SHA1SU0   = 4'd4,
      OP_SHA1SU1   = 4'd5,
      OP_SHA256H   = 4'd6,
      OP_SHA256H2  = 4'd7,
      OP_SHA256SU0 = 4'd8,
      OP_SHA256SU1 = 4'd9
   } op_type;

   // four 32-bit words, word 0 in bits 31..0
   typedef logic [3:0][31:0] words_type;

   typedef struct packed {
      op_type    op;
      words_type x;
      words_type y;
      words_type w;
   } stage_type;

   function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} >> s;
      return dbl[31:0];
   endfunction

   function automatic logic [31:0] f_choose(input logic [31:0] a, b, c);
      return ((b ^ c) & a) ^ c;
   endfunction

   function automatic logic [31:0] f_major(input logic [31:0] a, b, c);
      return (a & b) | ((a | b) & c);
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      return rotr32(v, 5'd2) ^ rotr32(v, 5'd13) ^ rotr32(v, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      return rotr32(v, 5'd6) ^ rotr32(v, 5'd11) ^ rotr32(v, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      return rotr32(v, 5'd7) ^ rotr32(v, 5'd18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      return rotr32(v, 5'd17) ^ rotr32(v, 5'd19) ^ (v >> 10);
   endfunction

   // One hash round on a stage; idx selects the message word.
   // SHA-1 keeps its scalar accumulator in y word 0.
   function automatic stage_type apply_round(input stage_type s, input logic [1:0] idx);
      stage_type   r;
      logic [31:0] f;
      logic [31:0] t1;
      logic [31:0] acc;
      r   = s;
      f   = '0;
      t1  = '0;
      acc = '0;
      case (s.op)
         OP_SHA1C, OP_SHA1P, OP_SHA1M: begin
            case (s.op)
               OP_SHA1C: f = f_choose(s.x[1], s.x[2], s.x[3]);
               OP_SHA1P: f = s.x[1] ^ s.x[2] ^ s.x[3];
               default:  f = f_major(s.x[1], s.x[2], s.x[3]);
            endcase
            acc     = s.y[0] + rotr32(s.x[0], 5'd27) + f + s.w[idx];
            r.x[3]  = s.x[2];
            r.x[2]  = rotr32(s.x[1], 5'd2);
            r.x[1]  = s.x[0];
            r.x[0]  = acc;
            r.y[0]  = s.x[3];
         end
         OP_SHA256H, OP_SHA256H2: begin
            t1 = s.y[3] + big_sigma1(s.y[0]) + f_choose(s.y[0], s.y[1], s.y[2]) + s.w[idx];
            r.x[3] = s.x[2];
            r.x[2] = s.x[1];
            r.x[1] = s.x[0];
            r.x[0] = t1 + big_sigma0(s.x[0]) + f_major(s.x[0], s.x[1], s.x[2]);
            r.y[3] = s.y[2];
            r.y[2] = s.y[1];
            r.y[1] = s.y[0];
            r.y[0] = t1 + s.x[3];
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   // Single-step instructions: result in one pass.
   function automatic words_type misc_result(input op_type op,
                                             input words_type d, n, m);
      words_type r;
      words_type t;
      r = '0;
      t = '0;
      case (op)
         OP_SHA1H: begin
            r[0] = rotr32(n[0], 5'd2);
         end
         OP_SHA1SU0: begin
            r[0] = d[2] ^ d[0] ^ m[0];
            r[1] = d[3] ^ d[1] ^ m[1];
            r[2] = n[0] ^ d[2] ^ m[2];
            r[3] = n[1] ^ d[3] ^ m[3];
         end
         OP_SHA1SU1: begin
            t[0] = d[0] ^ n[1];
            t[1] = d[1] ^ n[2];
            t[2] = d[2] ^ n[3];
            t[3] = d[3];
            r[0] = rotr32(t[0], 5'd31);
            r[1] = rotr32(t[1], 5'd31);
            r[2] = rotr32(t[2], 5'd31);
            r[3] = rotr32(t[3], 5'd31) ^ rotr32(t[0], 5'd30);
         end
         OP_SHA256SU0: begin
            r[0] = small_sigma0(d[1]) + d[0];
            r[1] = small_sigma0(d[2]) + d[1];
            r[2] = small_sigma0(d[3]) + d[2];
            r[3] = small_sigma0(n[0]) + d[3];
         end
         OP_SHA256SU1: begin
            r[0] = small_sigma1(m[2]) + d[0] + n[1];
            r[1] = small_sigma1(m[3]) + d[1] + n[2];
            r[2] = small_sigma1(r[0]) + d[2] + n[3];
            r[3] = small_sigma1(r[1]) + d[3] + m[0];
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

endpackage

[hdl/sha_crypto_instruction_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_crypto_instruction_unit
// Four-stage pipelined executor for the ARMv8 SHA-1 / SHA-256 instructions.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one instruction per transfer. req_tuser carries
//   the instruction type, req_tdata the d, n and m operand registers.
//   Response channel (rsp_*): one transfer per instruction carrying the new
//   128-bit d value, in request order.
//   Pipeline: a request passes through stages 0 to 3 in order, one hash
//   round per stage; the fourth stage is the output register.
//   Throughput: one instruction per cycle while rsp_tready is high; the
//   four-round hash work is spread over the four stages, and single-step
//   instructions (SHA1H, schedule updates) finish in the first stage and
//   ride along.
//   Reset: synchronous, active high; clears all stage valid bits, so the
//   pipeline comes up empty and ready.
//   Stall: when rsp_tready is low the output stage holds; upstream stages
//   keep filling any empty slot, and req_tready drops only when every
//   stage holds an item. No item is lost or repeated.
//   Undefined instruction types return an all-zero result.
// ----------------------------------------------------------------------------
module sha_crypto_instruction_unit
   import sci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // fields from bit 0 up: d_lo, d_hi, n_lo, n_hi, m_lo, m_hi
   input  logic [383:0] req_tdata,
   // fields from bit 0 up: type
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fields from bit 0 up: result_lo, result_hi
   output logic [127:0] rsp_tdata
);

   localparam int unsigned LAST = NUM_ROUNDS - 1;

   stage_type                 stage_ff [NUM_ROUNDS];
   stage_type                 stage_in [NUM_ROUNDS];
   logic [NUM_ROUNDS-1:0]     valid_ff;
   logic [NUM_ROUNDS-1:0]     valid_in;
   logic [NUM_ROUNDS-1:0]     advance;

   words_type d_words;
   words_type n_words;
   words_type m_words;
   op_type    req_op;
   stage_type entry;

   // unpack operands
   assign d_words = req_tdata[127:0];
   assign n_words = req_tdata[255:128];
   assign m_words = req_tdata[383:256];
   assign req_op  = op_type'(req_tuser);

   // a stage may load when it is empty or its contents move on
   always_comb begin
      advance[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int k = LAST - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_tready = advance[0];

   // load the working state for the first stage
   always_comb begin
      entry    = '0;
      entry.op = req_op;
      entry.w  = m_words;
      case (req_op)
         OP_SHA1C, OP_SHA1P, OP_SHA1M: begin
            entry.x    = d_words;
            entry.y[0] = n_words[0];
         end
         OP_SHA256H: begin
            entry.x = d_words;
            entry.y = n_words;
         end
         OP_SHA256H2: begin
            entry.x = n_words;
            entry.y = d_words;
         end
         default: begin
            entry.x = misc_result(req_op, d_words, n_words, m_words);
         end
      endcase
   end

   // one round per stage; single-step results pass through untouched
   always_comb begin
      stage_in[0] = apply_round(entry, 2'd0);
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NUM_ROUNDS; k++) begin
         stage_in[k] = apply_round(stage_ff[k-1], 2'(k));
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_ROUNDS; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // payload holds while the stage is stalled
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ROUNDS; k++) begin
         if (advance[k] && valid_in[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // SHA256H2 returns the y half, everything else the x half
   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = (stage_ff[LAST].op == OP_SHA256H2) ? stage_ff[LAST].y
                                                           : stage_ff[LAST].x;

endmodule

[tb/sha_crypto_instruction_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_crypto_instruction_unit_tb
// Self-checking bench for the SHA crypto instruction unit. A short directed
// table covers all-zero and all-one operands, every instruction type and the
// undefined types. A random phase of about 750 instructions follows. Every
// result is checked against an in-bench model of the ARMv8 SHA-1/SHA-256
// instructions. Both stream sides idle and stall at random, except during
// one long stretch where both run at full rate.
// ----------------------------------------------------------------------------
module sha_crypto_instruction_unit_tb
   import sci_pkg::*;
;

   // instruction codes above the last defined one must return zero
   localparam logic [3:0] OPC_UNDEF_FIRST = 4'd10;
   localparam logic [3:0] OPC_UNDEF_LAST  = 4'd15;

   localparam int RANDOM_INSTRS = 750;
   localparam int CALM_FIRST    = 250;   // both sides at full rate for
   localparam int CALM_LAST     = 400;   // instructions in this window
   localparam int IDLE_PERCENT  = 20;
   localparam int DRAIN_LIMIT   = 10000;
   localparam int TAIL_CYCLES   = 8;     // pipeline is four deep

   localparam logic [383:0] ALL_ZERO = '0;
   localparam logic [383:0] ALL_ONE  = '1;
   // alternating bit patterns, one per operand register
   localparam logic [383:0] CHECKER  = {{4{32'h5555_5555}}, {4{32'hAAAA_AAAA}},
                                        {4{32'h0F0F_F0F0}}};

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic [3:0]   opc;
      logic [383:0] data;
      logic         typed;
      logic [127:0] want;
   } instr_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // fields from bit 0 up: d_lo, d_hi, n_lo, n_hi, m_lo, m_hi
   logic [383:0] req_tdata  = '0;
   // fields from bit 0 up: type
   logic [3:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // fields from bit 0 up: result_lo, result_hi
   logic [127:0] rsp_tdata;

   logic [127:0] digest_q[$];      // expected new d values, oldest first
   logic [127:0] want_digest;
   logic         calm   = 1'b0;    // sender's own copy of the no-idle window
   logic         steady = 1'b0;    // registered copy for the receiver
   int           n_sent     = 0;
   int           n_directed = 0;
   int           n_checked  = 0;
   int           n_errors   = 0;

   sha_crypto_instruction_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Instruction model
   // ---------------------------------------------------------------------
   // every rotate amount used below lies in 1..31
   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] pick_bits(input logic [31:0] sel, a, b);
      return (sel & a) | (~sel & b);
   endfunction

   function automatic logic [31:0] vote_bits(input logic [31:0] a, b, c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic logic [31:0] sched_s1(input logic [31:0] v);
      return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
   endfunction

   // four SHA-1 rounds; the scalar e value enters as e_in
   function automatic words_type sha1_four(input logic [3:0] opc, input words_type st,
                                           input logic [31:0] e_in, input words_type msg);
      words_type   x;
      logic [31:0] acc;
      logic [31:0] f;
      logic [31:0] spill;
      int          i;
      x   = st;
      acc = e_in;
      for (i = 0; i < 4; i++) begin
         if (opc == OP_SHA1C) begin
            f = pick_bits(x[1], x[2], x[3]);
         end else if (opc == OP_SHA1P) begin
            f = x[1] ^ x[2] ^ x[3];
         end else begin
            f = vote_bits(x[1], x[2], x[3]);
         end
         acc   = acc + ror32(x[0], 27) + f + msg[i];
         spill = x[3];
         x[3]  = x[2];
         x[2]  = ror32(x[1], 2);
         x[1]  = x[0];
         x[0]  = acc;
         acc   = spill;
      end
      return x;
   endfunction

   // four SHA-256 rounds on the abcd (x) and efgh (y) halves; returns {y, x}
   function automatic logic [255:0] sha256_four(input words_type xs, ys, msg);
      words_type   x;
      words_type   y;
      logic [31:0] t1;
      logic [31:0] nx;
      logic [31:0] ny;
      int          i;
      x = xs;
      y = ys;
      for (i = 0; i < 4; i++) begin
         t1 = y[3] + (ror32(y[0], 6) ^ ror32(y[0], 11) ^ ror32(y[0], 25))
              + pick_bits(y[0], y[1], y[2]) + msg[i];
         nx = t1 + (ror32(x[0], 2) ^ ror32(x[0], 13) ^ ror32(x[0], 22))
              + vote_bits(x[0], x[1], x[2]);
         ny = t1 + x[3];
         x  = {x[2:0], nx};
         y  = {y[2:0], ny};
      end
      return {y, x};
   endfunction

   function automatic logic [127:0] predict_digest(input logic [3:0] opc,
                                                   input logic [383:0] data);
      words_type    d;
      words_type    n;
      words_type    m;
      words_type    r;
      words_type    t;
      logic [255:0] xy;
      int           i;
      d = data[127:0];
      n = data[255:128];
      m = data[383:256];
      r = '0;
      case (opc)
         OP_SHA1C, OP_SHA1P, OP_SHA1M: begin
            r = sha1_four(opc, d, n[0], m);
         end
         OP_SHA1H: begin
            r[0] = ror32(n[0], 2);
         end
         OP_SHA1SU0: begin
            r = {n[1] ^ d[3] ^ m[3], n[0] ^ d[2] ^ m[2],
                 d[3] ^ d[1] ^ m[1], d[2] ^ d[0] ^ m[0]};
         end
         OP_SHA1SU1: begin
            t = {d[3], d[2] ^ n[3], d[1] ^ n[2], d[0] ^ n[1]};
            for (i = 0; i < 4; i++) begin
               r[i] = ror32(t[i], 31);
            end
            r[3] = r[3] ^ ror32(t[0], 30);
         end
         OP_SHA256H: begin
            xy = sha256_four(d, n, m);
            r  = xy[127:0];
         end
         OP_SHA256H2: begin
            xy = sha256_four(n, d, m);
            r  = xy[255:128];
         end
         OP_SHA256SU0: begin
            t = {n[0], d[3], d[2], d[1]};
            for (i = 0; i < 4; i++) begin
               r[i] = (ror32(t[i], 7) ^ ror32(t[i], 18) ^ (t[i] >> 3)) + d[i];
            end
         end
         OP_SHA256SU1: begin
            r[0] = sched_s1(m[2]) + d[0] + n[1];
            r[1] = sched_s1(m[3]) + d[1] + n[2];
            r[2] = sched_s1(r[0]) + d[2] + n[3];
            r[3] = sched_s1(r[1]) + d[3] + m[0];
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: present one instruction, hold it until the transfer
   // ---------------------------------------------------------------------
   task automatic send_instr(input logic [3:0] opc, input logic [383:0] data,
                             input logic [127:0] want);
      // idle a random number of cycles outside the calm window
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opc;
      req_tdata  <= data;
      // signals read here still hold their values from before the edge
      do begin
         @(posedge clock);
      end while (!req_tready);
      digest_q.push_back(want);
      n_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, full rate in the calm window
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare every result transfer with the oldest expected d value
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            n_errors++;
            $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
         end else begin
            want_digest = digest_q.pop_front();
            n_checked++;
            if (rsp_tdata[63:0] !== want_digest[63:0]) begin
               n_errors++;
               $display("%0t: result_lo mismatch, expected %h actual %h",
                        $time, want_digest[63:0], rsp_tdata[63:0]);
            end
            if (rsp_tdata[127:64] !== want_digest[127:64]) begin
               n_errors++;
               $display("%0t: result_hi mismatch, expected %h actual %h",
                        $time, want_digest[127:64], rsp_tdata[127:64]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      instr_row_type dir_rows[$];
      instr_row_type row;
      logic [383:0]  data;
      logic [3:0]    opc;
      int            k;
      int            w;
      int            sel;
      int            guard;

      // all-zero operands give zero for every instruction
      dir_rows.push_back('{OP_SHA1C,     ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA1P,     ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA1M,     ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA256H,   ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA256H2,  ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA256SU0, ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA256SU1, ALL_ZERO, 1'b1, 128'h0});
      dir_rows.push_back('{OP_SHA1SU1,   ALL_ZERO, 1'b1, 128'h0});
      // three-way xor of all-ones words stays all ones
      dir_rows.push_back('{OP_SHA1SU0,   ALL_ONE,  1'b1, {128{1'b1}}});
      // SHA1H: rotated n word 0 only, upper words cleared
      dir_rows.push_back('{OP_SHA1H,     ALL_ONE,  1'b1, 128'h0000_0000_FFFF_FFFF});
      dir_rows.push_back('{OP_SHA1H,
                           {ALL_ONE[383:192], 64'hFFFF_FFFF_0000_0001, ALL_ONE[127:0]},
                           1'b1, 128'h0000_0000_4000_0000});
      // undefined types return zero whatever the operands
      dir_rows.push_back('{OPC_UNDEF_FIRST, ALL_ONE, 1'b1, 128'h0});
      dir_rows.push_back('{OPC_UNDEF_LAST,  CHECKER, 1'b1, 128'h0});
      // the rest go through the model
      dir_rows.push_back('{OP_SHA1C,     ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA1P,     ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA1M,     ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256H,   ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256H2,  ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256SU0, ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256SU1, ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA1SU1,   ALL_ONE,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA1C,     CHECKER,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256H,   CHECKER,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256H2,  CHECKER,  1'b0, 128'h0});
      dir_rows.push_back('{OP_SHA256SU1, CHECKER,  1'b0, 128'h0});

      // hold reset while the clock runs, then release
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_instr(row.opc, row.data,
                    row.typed ? row.want : predict_digest(row.opc, row.data));
         n_directed++;
      end

      for (k = 0; k < RANDOM_INSTRS; k++) begin
         calm    = (k >= CALM_FIRST) && (k < CALM_LAST);
         steady <= calm;
         // mostly defined instructions, a few undefined codes
         if ($urandom_range(99) < 8) begin
            opc = 4'($urandom_range(OPC_UNDEF_LAST, OPC_UNDEF_FIRST));
         end else begin
            opc = 4'($urandom_range(OP_SHA256SU1, OP_SHA1C));
         end
         // random words, with some all-zero and all-one words mixed in
         for (w = 0; w < 12; w++) begin
            sel = $urandom_range(19);
            data[w*32 +: 32] = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
         end
         send_instr(opc, data, predict_digest(opc, data));
      end
      req_tvalid <= 1'b0;

      // drain: wait for outstanding results, then a quiet tail
      guard = 0;
      while (digest_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (digest_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, digest_q.size());
      end

      $display("Issued %0d instructions (%0d directed), checked %0d results, %0d errors.",
               n_sent, n_directed, n_checked, n_errors);
      if (n_errors == 0 && digest_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Watchdog: far beyond the slowest correct run
   // ---------------------------------------------------------------------
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("FAIL");
      $finish;
   end

endmodule
